>>> hdl/rss_pkg.sv
package rss_pkg;

  // default coordinate width
  localparam int unsigned COORD_BITS_DEF = 16;

  // strip codes in emission order
  typedef enum logic [1:0] {
    SIDE_TOP    = 2'd0,
    SIDE_BOTTOM = 2'd1,
    SIDE_LEFT   = 2'd2,
    SIDE_RIGHT  = 2'd3
  } side_e;

  // number of candidate strips per item
  localparam int unsigned NUM_STRIPS = 4;

  // control flags of one picked result
  typedef struct packed {
    side_e side;
    logic  empty;
    logic  last;
  } pick_t;

endpackage

>>> hdl/rss_strip_pick.sv
module rss_strip_pick import rss_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] ol_i,
  input  logic signed [COORD_BITS-1:0] ot_i,
  input  logic signed [COORD_BITS-1:0] or_i,
  input  logic signed [COORD_BITS-1:0] ob_i,
  input  logic signed [COORD_BITS-1:0] il_i,
  input  logic signed [COORD_BITS-1:0] it_i,
  input  logic signed [COORD_BITS-1:0] ir_i,
  input  logic signed [COORD_BITS-1:0] ib_i,
  input  logic [NUM_STRIPS-1:0]        sent_i,
  output logic [NUM_STRIPS-1:0]        cond_o,
  output logic [NUM_STRIPS-1:0]        pick_mask_o,
  output logic signed [COORD_BITS-1:0] sl_o,
  output logic signed [COORD_BITS-1:0] st_o,
  output logic signed [COORD_BITS-1:0] sr_o,
  output logic signed [COORD_BITS-1:0] sb_o,
  output pick_t                        pick_o
);

  localparam logic signed [COORD_BITS-1:0] One = COORD_BITS'(1);

  logic [NUM_STRIPS-1:0] rem;
  logic [NUM_STRIPS-1:0] lsb;
  logic [NUM_STRIPS-1:0] rest;

  // strip existence tests
  always_comb begin
    cond_o[SIDE_TOP]    = ot_i < it_i;
    cond_o[SIDE_BOTTOM] = ib_i < ob_i;
    cond_o[SIDE_LEFT]   = ol_i < il_i;
    cond_o[SIDE_RIGHT]  = ir_i < or_i;
  end

  // lowest strip not yet sent, and whether any follows it
  assign rem         = cond_o & ~sent_i;
  assign lsb         = rem & (~rem + NUM_STRIPS'(1));
  assign rest        = rem & ~lsb;
  assign pick_mask_o = lsb;

  // corners of the picked strip
  always_comb begin
    sl_o         = '0;
    st_o         = '0;
    sr_o         = '0;
    sb_o         = '0;
    pick_o.side  = SIDE_TOP;
    pick_o.empty = 1'b0;
    pick_o.last  = (rest == '0);
    if (cond_o == '0) begin
      pick_o.empty = 1'b1;
      pick_o.last  = 1'b1;
    end else if (lsb[SIDE_TOP]) begin
      sl_o        = ol_i;
      st_o        = ot_i;
      sr_o        = or_i;
      sb_o        = it_i - One;
      pick_o.side = SIDE_TOP;
    end else if (lsb[SIDE_BOTTOM]) begin
      sl_o        = ol_i;
      st_o        = ib_i + One;
      sr_o        = or_i;
      sb_o        = ob_i;
      pick_o.side = SIDE_BOTTOM;
    end else if (lsb[SIDE_LEFT]) begin
      sl_o        = ol_i;
      st_o        = it_i;
      sr_o        = il_i - One;
      sb_o        = ib_i;
      pick_o.side = SIDE_LEFT;
    end else begin
      sl_o        = ir_i + One;
      st_o        = it_i;
      sr_o        = or_i;
      sb_o        = ib_i;
      pick_o.side = SIDE_RIGHT;
    end
  end

endmodule

>>> hdl/rect_subtract_strips.sv
// Cuts an inner rectangle out of an outer one (inclusive signed corners) and
// delivers the remaining strips in the order top, bottom, left, right, one
// result item per cycle while out_stall_i is low (the result register takes
// one result per cycle); the final result of each input item has last set, and
// an item leaving nothing gives a single result with empty_res and last set.
// An item (one to four results) is held in the input register, and the next
// item is taken in the cycle that the final result of the current one moves
// into the result register, so back-to-back items with one result each run at
// one item per cycle while out_stall_i is low. The inner rectangle is not
// clipped and corner order is not checked.
module rect_subtract_strips import rss_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] outer_left_i,
  input  logic signed [COORD_BITS-1:0] outer_top_i,
  input  logic signed [COORD_BITS-1:0] outer_right_i,
  input  logic signed [COORD_BITS-1:0] outer_bottom_i,
  input  logic signed [COORD_BITS-1:0] inner_left_i,
  input  logic signed [COORD_BITS-1:0] inner_top_i,
  input  logic signed [COORD_BITS-1:0] inner_right_i,
  input  logic signed [COORD_BITS-1:0] inner_bottom_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] strip_left_o,
  output logic signed [COORD_BITS-1:0] strip_top_o,
  output logic signed [COORD_BITS-1:0] strip_right_o,
  output logic signed [COORD_BITS-1:0] strip_bottom_o,
  output logic [1:0]                   strip_side_o,
  output logic                         empty_res_o,
  output logic                         last_o
);

  logic signed [COORD_BITS-1:0] ol_q, ot_q, or_q, ob_q;
  logic signed [COORD_BITS-1:0] il_q, it_q, ir_q, ib_q;
  logic                         in_vld_q;
  logic [NUM_STRIPS-1:0]        sent_q, sent_d;

  logic [NUM_STRIPS-1:0]        cond;
  logic [NUM_STRIPS-1:0]        pick_mask;
  logic signed [COORD_BITS-1:0] sl, st, sr, sb;
  pick_t                        pick;

  logic                         out_vld_q;
  logic signed [COORD_BITS-1:0] sl_q, st_q, sr_q, sb_q;
  pick_t                        res_q;

  logic                         out_free;
  logic                         emit;
  logic                         done;
  logic                         in_acc;

  // handshake glue
  assign out_free   = !out_vld_q || !out_stall_i;
  assign emit       = in_vld_q && out_free;
  assign done       = emit && pick.last;
  assign in_stall_o = in_vld_q && !done;
  assign in_acc     = in_valid_i && !in_stall_o;

  // strip selection on the held item
  rss_strip_pick #(
    .COORD_BITS(COORD_BITS)
  ) u_pick (
    .ol_i       (ol_q),
    .ot_i       (ot_q),
    .or_i       (or_q),
    .ob_i       (ob_q),
    .il_i       (il_q),
    .it_i       (it_q),
    .ir_i       (ir_q),
    .ib_i       (ib_q),
    .sent_i     (sent_q),
    .cond_o     (cond),
    .pick_mask_o(pick_mask),
    .sl_o       (sl),
    .st_o       (st),
    .sr_o       (sr),
    .sb_o       (sb),
    .pick_o     (pick)
  );

  // strips already delivered for the held item
  always_comb begin
    sent_d = sent_q;
    if (in_acc) begin
      sent_d = '0;
    end else if (emit) begin
      sent_d = sent_q | pick_mask;
    end
  end

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      sent_q   <= '0;
    end else begin
      sent_q <= sent_d;
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (done) begin
        in_vld_q <= 1'b0;
      end
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ol_q <= outer_left_i;
      ot_q <= outer_top_i;
      or_q <= outer_right_i;
      ob_q <= outer_bottom_i;
      il_q <= inner_left_i;
      it_q <= inner_top_i;
      ir_q <= inner_right_i;
      ib_q <= inner_bottom_i;
    end
  end

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= emit;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      sl_q  <= sl;
      st_q  <= st;
      sr_q  <= sr;
      sb_q  <= sb;
      res_q <= pick;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign strip_left_o   = sl_q;
  assign strip_top_o    = st_q;
  assign strip_right_o  = sr_q;
  assign strip_bottom_o = sb_q;
  assign strip_side_o   = res_q.side;
  assign empty_res_o    = res_q.empty;
  assign last_o         = res_q.last;

  // a new item only enters once the held one has given its final result
  a_accept_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (!in_vld_q || done))
    else $error("item accepted while previous item still pending");

  // delivered strips are always a subset of the existing ones
  a_sent_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q |-> ((sent_q & ~cond) == '0))
    else $error("strip marked sent that does not exist");

  // a picked result always lands in the result register
  a_emit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_vld_q)
    else $error("picked result lost");

  // an empty result is always the final one
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.empty) |-> res_q.last)
    else $error("empty result without last");

endmodule

>>> tb/rect_subtract_strips_test.sv
`timescale 1ns / 100ps

module rect_subtract_strips_test import rss_pkg::*; ();

  localparam int unsigned CW = COORD_BITS_DEF;
  localparam int unsigned RANDOM_ITEMS = 410;
  localparam int unsigned SETTLE_CYCLES = 20;

  // one input item: outer and inner rectangle
  typedef struct {
    logic signed [CW-1:0] outer_l, outer_t, outer_r, outer_b;
    logic signed [CW-1:0] inner_l, inner_t, inner_r, inner_b;
  } rect_pair_t;

  // one result item: a strip or the empty marker
  typedef struct {
    logic signed [CW-1:0] left, top, right, bottom;
    side_e                side;
    logic                 empty;
    logic                 last;
  } strip_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic signed [CW-1:0] outer_left_i, outer_top_i, outer_right_i, outer_bottom_i;
  logic signed [CW-1:0] inner_left_i, inner_top_i, inner_right_i, inner_bottom_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic signed [CW-1:0] strip_left_o, strip_top_o, strip_right_o, strip_bottom_o;
  logic [1:0]           strip_side_o;
  logic                 empty_res_o;
  logic                 last_o;

  rect_pair_t pending_rects[$];
  strip_t     expected_strips[$];
  rect_pair_t held_rect;
  bit         in_taken;
  int         error_count;
  int         rects_taken;
  int         strips_checked;
  int         empties_seen;
  int         side_seen[4];
  int         burst_left;
  int         gap_left;
  int         stall_mode;
  int         stall_phase;

  rect_subtract_strips dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .outer_left_i   (outer_left_i),
    .outer_top_i    (outer_top_i),
    .outer_right_i  (outer_right_i),
    .outer_bottom_i (outer_bottom_i),
    .inner_left_i   (inner_left_i),
    .inner_top_i    (inner_top_i),
    .inner_right_i  (inner_right_i),
    .inner_bottom_i (inner_bottom_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .strip_left_o   (strip_left_o),
    .strip_top_o    (strip_top_o),
    .strip_right_o  (strip_right_o),
    .strip_bottom_o (strip_bottom_o),
    .strip_side_o   (strip_side_o),
    .empty_res_o    (empty_res_o),
    .last_o         (last_o)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic report_error(input string msg);
    error_count++;
    $display("%0t ERROR %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] got,
                             input logic signed [31:0] want);
    if (got !== want)
      report_error($sformatf("result %0d: %s is %0d, expected %0d",
                             strips_checked, name, got, want));
  endtask

  function automatic strip_t make_strip(input logic signed [CW-1:0] l,
                                        input logic signed [CW-1:0] t,
                                        input logic signed [CW-1:0] rt,
                                        input logic signed [CW-1:0] b,
                                        input side_e sd);
    strip_t s;
    s.left   = l;
    s.top    = t;
    s.right  = rt;
    s.bottom = b;
    s.side   = sd;
    s.empty  = 1'b0;
    s.last   = 1'b0;
    return s;
  endfunction

  // strips left after cutting the inner rectangle out, in emission order
  function automatic void cut_rect(input rect_pair_t r);
    strip_t s[4];
    int     n;
    n = 0;
    if (r.outer_t < r.inner_t) begin
      s[n] = make_strip(r.outer_l, r.outer_t, r.outer_r, CW'(r.inner_t - 1), SIDE_TOP);
      n++;
    end
    if (r.inner_b < r.outer_b) begin
      s[n] = make_strip(r.outer_l, CW'(r.inner_b + 1), r.outer_r, r.outer_b, SIDE_BOTTOM);
      n++;
    end
    if (r.outer_l < r.inner_l) begin
      s[n] = make_strip(r.outer_l, r.inner_t, CW'(r.inner_l - 1), r.inner_b, SIDE_LEFT);
      n++;
    end
    if (r.inner_r < r.outer_r) begin
      s[n] = make_strip(CW'(r.inner_r + 1), r.inner_t, r.outer_r, r.inner_b, SIDE_RIGHT);
      n++;
    end
    // nothing remains: a single empty marker
    if (n == 0) begin
      s[0] = make_strip('0, '0, '0, '0, SIDE_TOP);
      s[0].empty = 1'b1;
      n = 1;
    end
    s[n-1].last = 1'b1;
    for (int k = 0; k < n; k++)
      expected_strips.push_back(s[k]);
  endfunction

  task automatic add_rect(input int ol, input int ot, input int orr, input int ob,
                          input int il, input int it, input int ir, input int ib);
    rect_pair_t r;
    r.outer_l = CW'(ol);
    r.outer_t = CW'(ot);
    r.outer_r = CW'(orr);
    r.outer_b = CW'(ob);
    r.inner_l = CW'(il);
    r.inner_t = CW'(it);
    r.inner_r = CW'(ir);
    r.inner_b = CW'(ib);
    pending_rects.push_back(r);
  endtask

  function automatic int rand_coord(input bit narrow);
    if (narrow)
      return int'($urandom_range(40)) - 20;
    return int'($urandom_range(65535)) - 32768;
  endfunction

  // edges are favoured so that touching sides come up often
  function automatic int pick_between(input int lo, input int hi);
    case ($urandom_range(3))
      0: return lo;
      1: return hi;
      default: return lo + int'($urandom_range(hi - lo));
    endcase
  endfunction

  function automatic rect_pair_t random_rect_pair();
    rect_pair_t r;
    int         kind;
    bit         narrow;
    int         a, b, c, d;
    kind   = $urandom_range(9);
    narrow = ($urandom_range(2) == 0);
    if (kind < 2) begin
      // raw noise, corners in any order
      r.outer_l = CW'($urandom_range(65535));
      r.outer_t = CW'($urandom_range(65535));
      r.outer_r = CW'($urandom_range(65535));
      r.outer_b = CW'($urandom_range(65535));
      r.inner_l = CW'($urandom_range(65535));
      r.inner_t = CW'($urandom_range(65535));
      r.inner_r = CW'($urandom_range(65535));
      r.inner_b = CW'($urandom_range(65535));
      return r;
    end
    a = rand_coord(narrow);
    b = rand_coord(narrow);
    c = rand_coord(narrow);
    d = rand_coord(narrow);
    r.outer_l = CW'((a < b) ? a : b);
    r.outer_r = CW'((a < b) ? b : a);
    r.outer_t = CW'((c < d) ? c : d);
    r.outer_b = CW'((c < d) ? d : c);
    if (kind < 8) begin
      // inner nested within outer
      a = pick_between(int'(r.outer_l), int'(r.outer_r));
      b = pick_between(a, int'(r.outer_r));
      c = pick_between(int'(r.outer_t), int'(r.outer_b));
      d = pick_between(c, int'(r.outer_b));
    end else begin
      // inner placed anywhere, possibly overlapping or outside
      a = rand_coord(narrow);
      b = rand_coord(narrow);
      c = rand_coord(narrow);
      d = rand_coord(narrow);
      if (a > b) begin
        a = a ^ b;
        b = a ^ b;
        a = a ^ b;
      end
      if (c > d) begin
        c = c ^ d;
        d = c ^ d;
        c = c ^ d;
      end
    end
    r.inner_l = CW'(a);
    r.inner_r = CW'(b);
    r.inner_t = CW'(c);
    r.inner_b = CW'(d);
    return r;
  endfunction

  // driver: bursts of items separated by random gaps
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_rects.size() != 0) begin
        held_rect = pending_rects.pop_front();
        outer_left_i   <= held_rect.outer_l;
        outer_top_i    <= held_rect.outer_t;
        outer_right_i  <= held_rect.outer_r;
        outer_bottom_i <= held_rect.outer_b;
        inner_left_i   <= held_rect.inner_l;
        inner_top_i    <= held_rect.inner_t;
        inner_right_i  <= held_rect.inner_r;
        inner_bottom_i <= held_rect.inner_b;
        in_valid_i     <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(16, 1);
          gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result stall pattern, with a new random mode chosen whenever the phase counter runs out
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_phase == 0) begin
        stall_mode  = $urandom_range(3);
        stall_phase = $urandom_range(300, 50);
      end else begin
        stall_phase--;
      end
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(2) == 0);
        2: out_stall_i <= (stall_phase % 3 == 0);
        default: out_stall_i <= ($urandom_range(7) != 0);
      endcase
    end
  end

  // monitor: input handshake feeds the predictor, results are checked in order
  always @(posedge clk_i) begin
    strip_t want;
    if (rst_ni) begin
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) begin
        cut_rect(held_rect);
        rects_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_strips.size() == 0) begin
          report_error($sformatf("result %0d arrived with none expected", strips_checked));
        end else begin
          want = expected_strips.pop_front();
          check_field("strip_left", 32'(strip_left_o), 32'(want.left));
          check_field("strip_top", 32'(strip_top_o), 32'(want.top));
          check_field("strip_right", 32'(strip_right_o), 32'(want.right));
          check_field("strip_bottom", 32'(strip_bottom_o), 32'(want.bottom));
          check_field("strip_side", {30'd0, strip_side_o}, {30'd0, want.side});
          check_field("empty_res", {31'd0, empty_res_o}, {31'd0, want.empty});
          check_field("last", {31'd0, last_o}, {31'd0, want.last});
          if (want.empty)
            empties_seen++;
          else
            side_seen[want.side]++;
        end
        strips_checked++;
      end
    end else begin
      in_taken = 1'b0;
    end
  end

  // stimulus and end of run
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    out_stall_i    = 1'b0;
    outer_left_i   = '0;
    outer_top_i    = '0;
    outer_right_i  = '0;
    outer_bottom_i = '0;
    inner_left_i   = '0;
    inner_top_i    = '0;
    inner_right_i  = '0;
    inner_bottom_i = '0;
    in_taken       = 1'b0;
    error_count    = 0;
    rects_taken    = 0;
    strips_checked = 0;
    empties_seen   = 0;
    side_seen      = '{default: 0};
    burst_left     = 1;
    gap_left       = 0;
    stall_mode     = 0;
    stall_phase    = 0;

    // directed: each strip alone, all four, none, range limits, odd shapes
    add_rect(0, 0, 10, 10, 3, 3, 6, 6);
    add_rect(0, 0, 10, 10, 0, 0, 10, 10);
    add_rect(0, 0, 10, 10, -5, -5, 15, 15);
    add_rect(0, 0, 10, 10, 0, 4, 10, 10);
    add_rect(0, 0, 10, 10, 0, 0, 10, 6);
    add_rect(0, 0, 10, 10, 4, 0, 10, 10);
    add_rect(0, 0, 10, 10, 0, 0, 7, 10);
    add_rect(-32768, -32768, 32767, 32767, -32767, -32767, 32766, 32766);
    add_rect(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
    add_rect(-32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768);
    add_rect(0, 0, 10, 10, 20, 20, 30, 30);
    add_rect(10, 10, 0, 0, 5, 5, 5, 5);
    add_rect(0, 0, 10, 10, 8, 8, 2, 2);
    add_rect(0, 0, 0, 0, 0, 0, 0, 0);
    add_rect(-1, -1, -1, -1, -1, -1, -1, -1);
    add_rect(21845, 21845, 21845, 21845, -21846, -21846, -21846, -21846);
    add_rect(-21846, -21846, -21846, -21846, 21845, 21845, 21845, 21845);
    add_rect(7, 7, 7, 7, 7, 7, 7, 7);
    add_rect(-100, -50, -10, -5, -60, -40, -20, -30);
    add_rect(0, 0, 10, 10, -5, -5, 5, 5);

    for (int k = 0; k < RANDOM_ITEMS; k++)
      pending_rects.push_back(random_rect_pair());

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_rects.size() != 0 || in_valid_i || expected_strips.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("%0d rectangle pairs taken, %0d results checked, %0d empty", rects_taken,
             strips_checked, empties_seen);
    $display("strips by side: top %0d bottom %0d left %0d right %0d, %0d errors",
             side_seen[0], side_seen[1], side_seen[2], side_seen[3], error_count);
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #3ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> rect_subtract_strips.f
hdl/rss_pkg.sv
hdl/rss_strip_pick.sv
hdl/rect_subtract_strips.sv
tb/rect_subtract_strips_test.sv
